### sv/led_strip_effect_generator_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef LED_STRIP_EFFECT_GENERATOR_DEFINES_SVH
`define LED_STRIP_EFFECT_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSFX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSFX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### sv/lsfx_pkg.sv
`default_nettype none

package lsfx_pkg;

   localparam int LED_COUNT_DEF = 64;
   localparam int IDX_W         = 6;
   localparam int ELAPSED_W     = 32;
   localparam int CNT_W         = 5;
   localparam int COLOR_W       = 8;
   localparam int BRIGHT_W      = 7;
   localparam int BLINK_W       = 16;
   localparam int STEP_W        = 13;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int HUE_W         = 9;
   localparam int HUE_FULL      = 360;
   localparam int SECTOR_SPAN   = 60;
   localparam int DIV_STAGES    = 8;
   localparam int DIV_STEPS     = 4;
   localparam int PROD_W        = COLOR_W + BRIGHT_W;
   localparam int RECIP_W       = 13;
   localparam int RECIP_MUL     = 5243;
   localparam int RECIP_SHIFT   = 19;
   localparam int ROUND_ADD     = 50;
   localparam int COLOR_MAX     = 255;
   localparam int BRIGHT_RESET  = 50;
   localparam int STEP_RESET    = 100;

   typedef enum logic [1:0] {
      MODE_BLANK   = 2'd0,
      MODE_STEADY  = 2'd1,
      MODE_RAINBOW = 2'd2,
      MODE_HUE     = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE   = 3'd0,
      CSR_RED    = 3'd1,
      CSR_GREEN  = 3'd2,
      CSR_BLUE   = 3'd3,
      CSR_BRIGHT = 3'd4,
      CSR_BLINK  = 3'd5,
      CSR_STEP   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      FD_IDLE,
      FD_RUN,
      FD_DONE
   } fd_state_type;

   typedef struct packed {
      mode_type                  mode;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
      logic [BRIGHT_W-1:0]       bright;
      logic [BLINK_W-1:0]        blink;
      logic [STEP_W-1:0]         step;
   } cfg_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] frame;
      logic                 dark;
   } frame_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
      logic             dark;
   } meta_type;

   typedef struct packed {
      meta_type             meta;
      logic [ELAPSED_W-1:0] x;
      logic [ELAPSED_W-1:0] f;
   } pixel_type;

endpackage

`default_nettype wire

### sv/lsfx_frame_div.sv
`default_nettype none

module lsfx_frame_div (
   input  wire                              clock,
   input  wire                              reset,
   input  lsfx_pkg::cfg_type                cfg,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [lsfx_pkg::ELAPSED_W-1:0]    req_elapsed_ms,
   input  wire                              take,
   output logic                             fr_valid,
   output lsfx_pkg::frame_type              fr
);
   import lsfx_pkg::*;

   fd_state_type           state_ff, state_in;
   logic [ELAPSED_W-1:0]   dvd_ff, dvd_in;
   logic [ELAPSED_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]      srem_ff, srem_in;
   logic [BLINK_W-1:0]     brem_ff, brem_in;
   logic                   bodd_ff, bodd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [STEP_W-1:0]      step_div;
   logic [STEP_W:0]        s2, s_sub;
   logic [BLINK_W:0]       b2, b_sub;
   logic                   sq, bq;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      srem_ff <= srem_in;
      brem_ff <= brem_in;
      bodd_ff <= bodd_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      step_div = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
      s2       = {srem_ff, dvd_ff[ELAPSED_W-1]};
      s_sub    = s2 - {1'b0, step_div};
      sq       = s2 >= {1'b0, step_div};
      b2       = {brem_ff, dvd_ff[ELAPSED_W-1]};
      b_sub    = b2 - {1'b0, cfg.blink};
      bq       = b2 >= {1'b0, cfg.blink};
      state_in = state_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      srem_in  = srem_ff;
      brem_in  = brem_ff;
      bodd_in  = bodd_ff;
      cnt_in   = cnt_ff;
      req_stall = 1'b1;
      fr_valid  = 1'b0;
      unique case (state_ff)
         FD_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dvd_in   = req_elapsed_ms;
               srem_in  = '0;
               brem_in  = '0;
               cnt_in   = '0;
               state_in = FD_RUN;
            end
         end
         FD_RUN: begin
            dvd_in  = {dvd_ff[ELAPSED_W-2:0], 1'b0};
            quo_in  = {quo_ff[ELAPSED_W-2:0], sq};
            srem_in = sq ? s_sub[STEP_W-1:0] : s2[STEP_W-1:0];
            brem_in = bq ? b_sub[BLINK_W-1:0] : b2[BLINK_W-1:0];
            bodd_in = bq;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ELAPSED_W-1)) begin
               state_in = FD_DONE;
            end
         end
         FD_DONE: begin
            fr_valid = 1'b1;
            if (take) begin
               state_in = FD_IDLE;
            end
         end
         default: begin
            state_in = FD_IDLE;
         end
      endcase
      fr.frame = quo_ff;
      fr.dark  = (cfg.mode == MODE_BLANK) ||
                 ((cfg.mode == MODE_STEADY) && (cfg.blink != '0) && bodd_ff);
   end

endmodule

`default_nettype wire

### sv/lsfx_pixel_seq.sv
`default_nettype none

module lsfx_pixel_seq #(
   parameter int LED_COUNT = lsfx_pkg::LED_COUNT_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  wire                    fr_valid,
   input  lsfx_pkg::frame_type    fr,
   output logic                   take,
   output logic                   pix_valid,
   output lsfx_pkg::pixel_type    pix
);
   import lsfx_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

   logic                  active_ff, active_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ELAPSED_W-1:0]  x_ff, x_in;
   logic [ELAPSED_W-1:0]  f_ff, f_in;
   logic                  dark_ff, dark_in;
   logic                  last_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      f_ff    <= f_in;
      dark_ff <= dark_in;
   end

   always_comb begin
      last_w    = (idx_ff == LAST_IDX);
      take      = fr_valid && (!active_ff || (en && last_w));
      active_in = active_ff;
      idx_in    = idx_ff;
      x_in      = x_ff;
      f_in      = f_ff;
      dark_in   = dark_ff;
      if (take) begin
         active_in = 1'b1;
         idx_in    = '0;
         x_in      = fr.frame * ELAPSED_W'(HUE_FULL);
         f_in      = fr.frame;
         dark_in   = fr.dark;
      end else if (active_ff && en) begin
         active_in = !last_w;
         idx_in    = idx_ff + IDX_W'(1);
         x_in      = x_ff + ELAPSED_W'(HUE_FULL);
      end
      pix_valid     = active_ff;
      pix.meta.idx  = idx_ff;
      pix.meta.last = last_w;
      pix.meta.dark = dark_ff;
      pix.x         = x_ff;
      pix.f         = f_ff;
   end

endmodule

`default_nettype wire

### sv/lsfx_hue_pipe.sv
`default_nettype none

module lsfx_hue_pipe #(
   parameter int LED_COUNT = lsfx_pkg::LED_COUNT_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          flow,
   input  wire                          pix_valid,
   input  lsfx_pkg::pixel_type          pix,
   output logic                         hue_valid,
   output logic [lsfx_pkg::HUE_W-1:0]   hue,
   output lsfx_pkg::meta_type           meta
);
   import lsfx_pkg::*;

   localparam int REM_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [REM_W:0] DIV_N   = (REM_W + 1)'(LED_COUNT);
   localparam logic [HUE_W:0] HUE_MOD = (HUE_W + 1)'(HUE_FULL);

   logic                 vld_ff  [0:DIV_STAGES];
   meta_type             meta_ff [0:DIV_STAGES];
   logic [ELAPSED_W-1:0] x_ff    [0:DIV_STAGES];
   logic [ELAPSED_W-1:0] f_ff    [0:DIV_STAGES];
   logic [REM_W-1:0]     drem_ff [0:DIV_STAGES];
   logic [HUE_W-1:0]     hrem_ff [0:DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= pix_valid;
      end
      if (en) begin
         meta_ff[0] <= pix.meta;
         x_ff[0]    <= pix.x;
         f_ff[0]    <= pix.f;
         drem_ff[0] <= '0;
         hrem_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
      logic [ELAPSED_W-1:0] x_in;
      logic [ELAPSED_W-1:0] f_in;
      logic [REM_W-1:0]     drem_in;
      logic [HUE_W-1:0]     hrem_in;

      always_comb begin
         logic [REM_W:0] d2;
         logic [HUE_W:0] h2;
         logic           qb;
         x_in    = x_ff[k-1];
         f_in    = f_ff[k-1];
         drem_in = drem_ff[k-1];
         hrem_in = hrem_ff[k-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            d2 = {drem_in, x_in[ELAPSED_W-1]};
            qb = (d2 >= DIV_N);
            if (qb) begin
               d2 = d2 - DIV_N;
            end
            drem_in = d2[REM_W-1:0];
            h2 = {hrem_in, (flow ? f_in[ELAPSED_W-1] : qb)};
            if (h2 >= HUE_MOD) begin
               h2 = h2 - HUE_MOD;
            end
            hrem_in = h2[HUE_W-1:0];
            x_in = {x_in[ELAPSED_W-2:0], 1'b0};
            f_in = {f_in[ELAPSED_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (en) begin
            meta_ff[k] <= meta_ff[k-1];
            x_ff[k]    <= x_in;
            f_ff[k]    <= f_in;
            drem_ff[k] <= drem_in;
            hrem_ff[k] <= hrem_in;
         end
      end
   end

   assign hue_valid = vld_ff[DIV_STAGES];
   assign hue       = hrem_ff[DIV_STAGES];
   assign meta      = meta_ff[DIV_STAGES];

endmodule

`default_nettype wire

### sv/lsfx_color_pipe.sv
`default_nettype none

module lsfx_color_pipe (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            en,
   input  lsfx_pkg::cfg_type              cfg,
   input  wire                            hue_valid,
   input  wire [lsfx_pkg::HUE_W-1:0]      hue,
   input  lsfx_pkg::meta_type             meta,
   output logic                           rsp_valid,
   output logic [lsfx_pkg::IDX_W-1:0]     rsp_led_index,
   output logic [lsfx_pkg::COLOR_W-1:0]   rsp_red_out,
   output logic [lsfx_pkg::COLOR_W-1:0]   rsp_green_out,
   output logic [lsfx_pkg::COLOR_W-1:0]   rsp_blue_out,
   output logic                           rsp_last_pixel
);
   import lsfx_pkg::*;

   localparam int SCL_W = PROD_W + RECIP_W;

   logic               c1_vld_ff, c2_vld_ff, c3_vld_ff, rsp_valid_ff;
   meta_type           c1_meta_ff, c2_meta_ff, c3_meta_ff;
   logic [2:0]         c1_sec_ff, sec_in;
   logic [5:0]         c1_rem_ff, rem_in;
   logic [COLOR_W-1:0] c2_r_ff, c2_g_ff, c2_b_ff, r_in, g_in, b_in;
   logic [PROD_W-1:0]  c3_r_ff, c3_g_ff, c3_b_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [COLOR_W-1:0] red_in, green_in, blue_in;
   logic               last_ff;
   logic [COLOR_W-1:0] ramp, down;

   function automatic logic [PROD_W-1:0] lsfx_round(input logic [COLOR_W-1:0] v,
                                                    input logic [BRIGHT_W-1:0] p);
      return PROD_W'(v) * PROD_W'(p) + PROD_W'(ROUND_ADD);
   endfunction

   function automatic logic [COLOR_W-1:0] lsfx_div(input logic [PROD_W-1:0] n);
      logic [SCL_W-1:0] q;
      q = (SCL_W'(n) * SCL_W'(RECIP_MUL)) >> RECIP_SHIFT;
      return (q > SCL_W'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX) : q[COLOR_W-1:0];
   endfunction

   always_comb begin
      priority if (hue >= HUE_W'(5 * SECTOR_SPAN)) begin
         sec_in = 3'd5;
      end else if (hue >= HUE_W'(4 * SECTOR_SPAN)) begin
         sec_in = 3'd4;
      end else if (hue >= HUE_W'(3 * SECTOR_SPAN)) begin
         sec_in = 3'd3;
      end else if (hue >= HUE_W'(2 * SECTOR_SPAN)) begin
         sec_in = 3'd2;
      end else if (hue >= HUE_W'(SECTOR_SPAN)) begin
         sec_in = 3'd1;
      end else begin
         sec_in = 3'd0;
      end
      rem_in = 6'(hue - HUE_W'(sec_in) * HUE_W'(SECTOR_SPAN));
   end

   always_comb begin
      ramp = COLOR_W'((11'(c1_rem_ff) * 11'd17) >> 2);
      down = COLOR_W'(COLOR_MAX) - ramp;
      unique case (c1_sec_ff)
         3'd0: begin r_in = 8'hFF; g_in = ramp;  b_in = 8'h00; end
         3'd1: begin r_in = down;  g_in = 8'hFF; b_in = 8'h00; end
         3'd2: begin r_in = 8'h00; g_in = 8'hFF; b_in = ramp;  end
         3'd3: begin r_in = 8'h00; g_in = down;  b_in = 8'hFF; end
         3'd4: begin r_in = ramp;  g_in = 8'h00; b_in = 8'hFF; end
         default: begin r_in = 8'hFF; g_in = 8'h00; b_in = down; end
      endcase
      if (cfg.mode == MODE_STEADY) begin
         r_in = cfg.red;
         g_in = cfg.green;
         b_in = cfg.blue;
      end
   end

   always_comb begin
      red_in   = c3_meta_ff.dark ? '0 : lsfx_div(c3_r_ff);
      green_in = c3_meta_ff.dark ? '0 : lsfx_div(c3_g_ff);
      blue_in  = c3_meta_ff.dark ? '0 : lsfx_div(c3_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff    <= 1'b0;
         c2_vld_ff    <= 1'b0;
         c3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         c1_vld_ff    <= hue_valid;
         c2_vld_ff    <= c1_vld_ff;
         c3_vld_ff    <= c2_vld_ff;
         rsp_valid_ff <= c3_vld_ff;
      end
      if (en) begin
         c1_meta_ff <= meta;
         c1_sec_ff  <= sec_in;
         c1_rem_ff  <= rem_in;
         c2_meta_ff <= c1_meta_ff;
         c2_r_ff    <= r_in;
         c2_g_ff    <= g_in;
         c2_b_ff    <= b_in;
         c3_meta_ff <= c2_meta_ff;
         c3_r_ff    <= lsfx_round(c2_r_ff, cfg.bright);
         c3_g_ff    <= lsfx_round(c2_g_ff, cfg.bright);
         c3_b_ff    <= lsfx_round(c2_b_ff, cfg.bright);
         idx_ff     <= c3_meta_ff.idx;
         last_ff    <= c3_meta_ff.last;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_index  = idx_ff;
   assign rsp_red_out    = red_ff;
   assign rsp_green_out  = green_ff;
   assign rsp_blue_out   = blue_ff;
   assign rsp_last_pixel = last_ff;

endmodule

`default_nettype wire

### sv/led_strip_effect_generator.sv
// LED strip effect generator.
// A request transaction carries the milliseconds elapsed since the effect was
// set; the block answers with LED_COUNT response transactions, one color per
// LED in strip order, the final one flagged by rsp_last_pixel.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low. Registers are to be written through csr_wen,
// csr_index and csr_wdata only while no frame is in flight; the block itself
// does not enforce this. A request runs through a bit-serial divider (one
// quotient bit per cycle for the frame number and the blink phase), and the
// divider takes no new request until its finished frame has been taken by the
// pixel sequencer. Pixels are then issued one per cycle, unless rsp_stall
// holds them, into a 13-stage pipeline (hue division and modulo over 8 stages,
// then color, scaling and the output register). A new request is taken while
// the previous frame streams out. rsp_stall freezes the whole pixel pipeline;
// no pixel is dropped or repeated. Synchronous reset empties the pipeline and
// loads the register defaults.
`default_nettype none
`include "led_strip_effect_generator_defines.svh"

module led_strip_effect_generator #(
   parameter int LED_COUNT = lsfx_pkg::LED_COUNT_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire [lsfx_pkg::ELAPSED_W-1:0]     req_elapsed_ms,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [lsfx_pkg::IDX_W-1:0]        rsp_led_index,
   output logic [lsfx_pkg::COLOR_W-1:0]      rsp_red_out,
   output logic [lsfx_pkg::COLOR_W-1:0]      rsp_green_out,
   output logic [lsfx_pkg::COLOR_W-1:0]      rsp_blue_out,
   output logic                              rsp_last_pixel,
   input  wire                               csr_wen,
   input  wire [lsfx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [lsfx_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lsfx_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       en;
   logic       fr_valid, take;
   frame_type  fr;
   logic       pix_valid;
   pixel_type  pix;
   logic       hue_valid;
   logic [HUE_W-1:0] hue;
   meta_type   hue_meta;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:   cfg_in.mode   = mode_type'(csr_wdata[1:0]);
            CSR_RED:    cfg_in.red    = csr_wdata[COLOR_W-1:0];
            CSR_GREEN:  cfg_in.green  = csr_wdata[COLOR_W-1:0];
            CSR_BLUE:   cfg_in.blue   = csr_wdata[COLOR_W-1:0];
            CSR_BRIGHT: cfg_in.bright = csr_wdata[BRIGHT_W-1:0];
            CSR_BLINK:  cfg_in.blink  = csr_wdata[BLINK_W-1:0];
            CSR_STEP:   cfg_in.step   = csr_wdata[STEP_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_BLANK;
         cfg_ff.red    <= '0;
         cfg_ff.green  <= '0;
         cfg_ff.blue   <= '0;
         cfg_ff.bright <= BRIGHT_W'(BRIGHT_RESET);
         cfg_ff.blink  <= '0;
         cfg_ff.step   <= STEP_W'(STEP_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign en = !rsp_valid || !rsp_stall;

   lsfx_frame_div u_frame_div (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elapsed_ms (req_elapsed_ms),
      .take           (take),
      .fr_valid       (fr_valid),
      .fr             (fr)
   );

   lsfx_pixel_seq #(.LED_COUNT(LED_COUNT)) u_pixel_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .fr_valid  (fr_valid),
      .fr        (fr),
      .take      (take),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   lsfx_hue_pipe #(.LED_COUNT(LED_COUNT)) u_hue_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .flow      (cfg_ff.mode == MODE_HUE),
      .pix_valid (pix_valid),
      .pix       (pix),
      .hue_valid (hue_valid),
      .hue       (hue),
      .meta      (hue_meta)
   );

   lsfx_color_pipe u_color_pipe (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .cfg            (cfg_ff),
      .hue_valid      (hue_valid),
      .hue            (hue),
      .meta           (hue_meta),
      .rsp_valid      (rsp_valid),
      .rsp_led_index  (rsp_led_index),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_last_pixel (rsp_last_pixel)
   );

   `LSFX_ASSERT_SAME(a_last_index, clock, reset, rsp_valid && rsp_last_pixel,
      rsp_led_index == IDX_W'(LED_COUNT - 1))
   `LSFX_ASSERT_NEXT(a_frame_continues, clock, reset, pix_valid && en && !pix.meta.last,
      pix_valid)
   `LSFX_ASSERT_NEXT(a_frame_taken, clock, reset, fr_valid && !pix_valid, pix_valid)
   `LSFX_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lsfx_pkg::*;

   localparam int NUM_LEDS = LED_COUNT_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 15;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 60;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } exp_pixel_type;

   typedef struct {
      logic               write_cfg;
      mode_type           mode;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [6:0]         bright;
      logic [15:0]        blink;
      logic [12:0]        step;
      logic [31:0]        elapsed;
      logic               has_color;
      logic [7:0]         exp_red;
      logic [7:0]         exp_green;
      logic [7:0]         exp_blue;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ELAPSED_W-1:0] req_elapsed_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [IDX_W-1:0] rsp_led_index;
   logic [COLOR_W-1:0] rsp_red_out;
   logic [COLOR_W-1:0] rsp_green_out;
   logic [COLOR_W-1:0] rsp_blue_out;
   logic rsp_last_pixel;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type strip_cfg;
   exp_pixel_type pending_pixels[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   frame_row_type rows[18];

   led_strip_effect_generator i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_led_index(rsp_led_index),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_last_pixel(rsp_last_pixel),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("led_strip_effect_generator test failed");
         $finish;
      end
   end

   function automatic logic [7:0] scale_level(logic [31:0] level, logic [31:0] pct);
      logic [31:0] scaled;
      scaled = (level * pct + 32'd50) / 32'd100;
      return (scaled > 32'd255) ? 8'd255 : scaled[7:0];
   endfunction

   function automatic exp_pixel_type hue_pixel(logic [31:0] hue, logic [31:0] pct);
      logic [31:0] sector;
      logic [31:0] up;
      logic [31:0] down;
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
      exp_pixel_type px;
      sector = (hue % 32'd360) / 32'd60;
      up = (hue % 32'd60) * 32'd255 / 32'd60;
      down = 32'd255 - up;
      case (sector)
         0: begin r = 255; g = up; b = 0; end
         1: begin r = down; g = 255; b = 0; end
         2: begin r = 0; g = 255; b = up; end
         3: begin r = 0; g = down; b = 255; end
         4: begin r = up; g = 0; b = 255; end
         default: begin r = 255; g = 0; b = down; end
      endcase
      px = '0;
      px.red = scale_level(r, pct);
      px.green = scale_level(g, pct);
      px.blue = scale_level(b, pct);
      return px;
   endfunction

   // Appends the pixels of one frame to the queue of pending pixels.
   task automatic predict_frame(input logic [31:0] elapsed, output exp_pixel_type first_px);
      logic [31:0] step;
      logic [31:0] frame;
      logic [31:0] pct;
      logic [31:0] hue;
      logic dark;
      exp_pixel_type base;
      exp_pixel_type px;
      step = (strip_cfg.step == 0) ? 32'd1 : 32'(strip_cfg.step);
      frame = elapsed / step;
      pct = 32'(strip_cfg.bright);
      dark = (strip_cfg.mode == MODE_BLANK) ||
             (strip_cfg.mode == MODE_STEADY && strip_cfg.blink != 0 &&
              ((elapsed / 32'(strip_cfg.blink)) & 32'd1) != 0);
      base = '0;
      if (strip_cfg.mode == MODE_STEADY) begin
         base.red = scale_level(32'(strip_cfg.red), pct);
         base.green = scale_level(32'(strip_cfg.green), pct);
         base.blue = scale_level(32'(strip_cfg.blue), pct);
      end else if (strip_cfg.mode == MODE_HUE) begin
         base = hue_pixel(frame % 32'd360, pct);
      end
      for (int i = 0; i < NUM_LEDS; i++) begin
         px = base;
         if (dark) begin
            px = '0;
         end else if (strip_cfg.mode == MODE_RAINBOW) begin
            hue = (((32'(i) + frame) * 32'd360) / 32'(NUM_LEDS)) % 32'd360;
            px = hue_pixel(hue, pct);
         end
         px.idx = i[IDX_W-1:0];
         px.last = (i == NUM_LEDS - 1);
         if (i == 0) first_px = px;
         pending_pixels.push_back(px);
      end
   endtask

   always @(posedge clock) begin
      exp_pixel_type got;
      exp_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_led_index, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_last_pixel};
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected pixel %p", got);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("pixel mismatch: expected %p actual %p", want, got);
            end
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 14);
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value, input int width);
      logic [15:0] data;
      data = value | 16'($urandom << width);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MODE: strip_cfg.mode = mode_type'(data[1:0]);
         CSR_RED: strip_cfg.red = data[7:0];
         CSR_GREEN: strip_cfg.green = data[7:0];
         CSR_BLUE: strip_cfg.blue = data[7:0];
         CSR_BRIGHT: strip_cfg.bright = data[6:0];
         CSR_BLINK: strip_cfg.blink = data;
         CSR_STEP: strip_cfg.step = data[12:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input frame_row_type r);
      write_reg(CSR_MODE, 16'(r.mode), 2);
      write_reg(CSR_RED, 16'(r.red), 8);
      write_reg(CSR_GREEN, 16'(r.green), 8);
      write_reg(CSR_BLUE, 16'(r.blue), 8);
      write_reg(CSR_BRIGHT, 16'(r.bright), 7);
      write_reg(CSR_BLINK, r.blink, 16);
      write_reg(CSR_STEP, 16'(r.step), 13);
      csr_wen <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic send_frame(input logic [31:0] elapsed, output exp_pixel_type first_px);
      while (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elapsed_ms <= elapsed;
      do @(posedge clock); while (req_stall);
      predict_frame(elapsed, first_px);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_elapsed;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(5000);
         2: return 32'hFFFFFFFF - $urandom_range(100000);
         default: return $urandom_range(2000000);
      endcase
   endfunction

   function automatic frame_row_type random_settings;
      frame_row_type r;
      r = '{mode: MODE_BLANK, default: '0};
      r.write_cfg = 1'b1;
      r.mode = mode_type'($urandom_range(3));
      r.red = 8'($urandom);
      r.green = 8'($urandom);
      r.blue = 8'($urandom);
      case ($urandom_range(3))
         0: r.bright = 7'd100;
         1: r.bright = 7'd127;
         default: r.bright = 7'($urandom_range(127));
      endcase
      case ($urandom_range(2))
         0: r.blink = 16'd0;
         1: r.blink = 16'($urandom_range(1, 2000));
         default: r.blink = 16'($urandom);
      endcase
      r.step = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(20, 500));
      return r;
   endfunction

   initial begin
      exp_pixel_type first_px;
      frame_row_type r;
      strip_cfg = '0;
      strip_cfg.bright = BRIGHT_W'(BRIGHT_RESET);
      strip_cfg.step = STEP_W'(STEP_RESET);
      rows[0] = '{0, MODE_BLANK, 0, 0, 0, 0, 0, 0, 32'd0, 1, 0, 0, 0};
      rows[1] = '{1, MODE_BLANK, 255, 255, 255, 100, 0, 100, 32'hFFFFFFFF, 1, 0, 0, 0};
      rows[2] = '{1, MODE_STEADY, 255, 255, 255, 100, 0, 100, 32'd0, 1, 255, 255, 255};
      rows[3] = '{1, MODE_STEADY, 255, 0, 128, 127, 0, 100, 32'd5, 1, 255, 0, 163};
      rows[4] = '{1, MODE_STEADY, 255, 255, 255, 0, 0, 100, 32'd7, 1, 0, 0, 0};
      rows[5] = '{1, MODE_STEADY, 200, 1, 2, 50, 0, 100, 32'd9, 1, 100, 1, 1};
      rows[6] = '{1, MODE_STEADY, 200, 1, 2, 50, 1000, 100, 32'd1500, 1, 0, 0, 0};
      rows[7] = '{1, MODE_STEADY, 200, 1, 2, 50, 1000, 100, 32'd999, 1, 100, 1, 1};
      rows[8] = '{1, MODE_STEADY, 10, 20, 30, 100, 65535, 100, 32'hFFFFFFFF, 1, 0, 0, 0};
      rows[9] = '{1, MODE_STEADY, 10, 20, 30, 100, 1, 100, 32'hFFFFFFFF, 1, 0, 0, 0};
      rows[10] = '{1, MODE_HUE, 0, 0, 0, 100, 0, 100, 32'd0, 1, 255, 0, 0};
      rows[11] = '{1, MODE_HUE, 0, 0, 0, 100, 0, 0, 32'd60, 1, 255, 255, 0};
      rows[12] = '{1, MODE_HUE, 0, 0, 0, 127, 0, 8191, 32'hFFFFFFFF, 0, 0, 0, 0};
      rows[13] = '{1, MODE_HUE, 0, 0, 0, 100, 0, 1, 32'd359, 1, 255, 0, 5};
      rows[14] = '{1, MODE_RAINBOW, 0, 0, 0, 100, 0, 100, 32'd0, 1, 255, 0, 0};
      rows[15] = '{1, MODE_RAINBOW, 0, 0, 0, 100, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0};
      rows[16] = '{1, MODE_RAINBOW, 0, 0, 0, 127, 0, 20, 32'd123456, 0, 0, 0, 0};
      rows[17] = '{1, MODE_RAINBOW, 0, 0, 0, 0, 0, 8191, 32'hDEADBEEF, 1, 0, 0, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[n]) begin
         if (rows[n].write_cfg) begin
            drain();
            write_settings(rows[n]);
         end
         send_frame(rows[n].elapsed, first_px);
         if (rows[n].has_color &&
             {first_px.red, first_px.green, first_px.blue} !==
             {rows[n].exp_red, rows[n].exp_green, rows[n].exp_blue}) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("row %0d first pixel: expected %0d %0d %0d actual %0d %0d %0d", n,
                        rows[n].exp_red, rows[n].exp_green, rows[n].exp_blue,
                        first_px.red, first_px.green, first_px.blue);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         r = random_settings();
         write_settings(r);
         quiet = (phase == 3);
         if (phase == 5) hold_request = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_frame(random_elapsed(), first_px);
         end
         quiet = 1'b0;
      end

      drain();
      if (mismatch_count == 0) begin
         $display("led_strip_effect_generator test passed");
      end else begin
         $display("led_strip_effect_generator test failed");
      end
      $finish;
   end

endmodule
